>>> rtl/core/signed_exp_golomb_bit_writer_assert.svh
// Assertion macros shared by the bit writer RTL.
// Used by sege_queue and sege_back; no other dependencies.
`ifndef SIGNED_EXP_GOLOMB_BIT_WRITER_ASSERT_SVH
`define SIGNED_EXP_GOLOMB_BIT_WRITER_ASSERT_SVH

// same-cycle implication
`define SEGE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SEGE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sege_pkg.sv
// Types and constants for the signed Exp-Golomb bit writer.
// No dependencies.
package sege_pkg;

    localparam int WORD_BITS  = 32;
    localparam int VALUE_BITS = 17;
    localparam int NBITS_W    = 6;
    localparam int LEN_W      = 5;
    localparam int FILL_W     = 5;
    localparam int CAP_W      = 24;

    localparam logic [CAP_W-1:0] CAP_RESET = 24'hFF_FFFF;

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] coefficient;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_item_t;

    // classified request handed from front to back
    typedef struct packed {
        logic                  is_flush;
        logic [VALUE_BITS-1:0] value;
        logic [NBITS_W-1:0]    nbits;
    } cmd_t;

endpackage

>>> rtl/core/sege_front.sv
// Front end: accepts requests and maps coefficients to code value and length.
// Depends on sege_pkg.
module sege_front (
    input  logic             in_valid,
    output logic             in_ready,
    input  sege_pkg::in_item_t in_data,
    input  logic             q_full,
    output logic             push,
    output sege_pkg::cmd_t   cmd
);
    import sege_pkg::*;

    logic signed [17:0]    twice;
    logic [17:0]           neg_val;
    logic [VALUE_BITS-1:0] value;
    logic [LEN_W-1:0]      len;

    assign twice   = {in_data.coefficient[15], in_data.coefficient, 1'b0};
    assign neg_val = 18'd1 - twice;

    always_comb
    begin
        if (in_data.coefficient > 16'sd0)
            value = twice[VALUE_BITS-1:0];
        else
            value = neg_val[VALUE_BITS-1:0];
    end

    // position of the leading one
    always_comb
    begin
        len = '0;
        for (int i = 0; i < VALUE_BITS; i++)
        begin
            if (value[i])
                len = LEN_W'(i);
        end
    end

    assign in_ready     = !q_full;
    assign push         = in_valid && !q_full;
    assign cmd.is_flush = (in_data.req_type == REQ_FLUSH);
    assign cmd.value    = value;
    assign cmd.nbits    = {len, 1'b1};

endmodule

>>> rtl/core/sege_queue.sv
// Small FIFO of classified requests between front and back.
// Depends on sege_pkg and the assertion header.
`include "signed_exp_golomb_bit_writer_assert.svh"
module sege_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  sege_pkg::cmd_t push_data,
    input  logic           pop,
    output sege_pkg::cmd_t head,
    output logic           full,
    output logic           empty
);
    import sege_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `SEGE_ASSERT_NOW(a_no_pop_empty, clk, rst_n, pop, !empty, "pop from empty queue")
    `SEGE_ASSERT_NEXT(a_push_only_count, clk, rst_n, push && !pop, count_reg != '0, "push lost")

endmodule

>>> rtl/core/sege_back.sv
// Back end: packs codes into the 32-bit word, applies capacity, drains bytes.
// Depends on sege_pkg and the assertion header.
`include "signed_exp_golomb_bit_writer_assert.svh"
module sege_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [sege_pkg::CAP_W-1:0]   cfg_data,
    input  logic                         q_empty,
    input  sege_pkg::cmd_t               head,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_ready,
    output sege_pkg::out_item_t          out_data
);
    import sege_pkg::*;

    logic [WORD_BITS-1:0]   acc_reg, acc_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;
    logic [CAP_W-1:0]       bw_reg, bw_next;
    logic [CAP_W-1:0]       cap_reg;
    logic [2*WORD_BITS-1:0] buf_reg, buf_next;
    logic [3:0]             cnt_reg, cnt_next;

    logic [6:0]             total;
    logic [6:0]             sh;
    logic [2*WORD_BITS-1:0] win;
    logic [1:0]             nw, ew;
    logic                   fit4, fit8;
    logic [2:0]             nb, fl_cnt;
    logic [5:0]             fill_round;
    logic [CAP_W-1:0]       avail;
    logic                   drain;

    assign drain     = out_valid && out_ready;
    assign pop       = !q_empty && (cnt_reg == 4'd0 || (cnt_reg == 4'd1 && out_ready));
    assign out_valid = (cnt_reg != 4'd0);
    assign out_data.out_byte    = buf_reg[2*WORD_BITS-1 -: 8];
    assign out_data.last_of_run = (cnt_reg == 4'd1);

    // encode path
    assign total = 7'(fill_reg) + 7'(head.nbits);
    assign sh    = 7'd64 - total;
    assign win   = {acc_reg, {WORD_BITS{1'b0}}}
                 | ({{(2*WORD_BITS-VALUE_BITS){1'b0}}, head.value} << sh);
    assign nw    = total[6] ? 2'd2 : (total[5] ? 2'd1 : 2'd0);
    assign fit4  = ({2'b00, bw_reg} + 26'd4) <= {2'b00, cap_reg};
    assign fit8  = ({2'b00, bw_reg} + 26'd8) <= {2'b00, cap_reg};

    always_comb
    begin
        if (nw == 2'd0 || !fit4)
            ew = 2'd0;
        else if (nw == 2'd2 && fit8)
            ew = 2'd2;
        else
            ew = 2'd1;
    end

    // flush path
    assign fill_round = 6'(fill_reg) + 6'd7;
    assign nb         = 3'(fill_round >> 3);
    assign avail      = (cap_reg > bw_reg) ? cap_reg - bw_reg : '0;
    assign fl_cnt     = (avail < CAP_W'(nb)) ? avail[2:0] : nb;

    always_comb
    begin
        acc_next  = acc_reg;
        fill_next = fill_reg;
        bw_next   = bw_reg;
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        if (drain)
        begin
            buf_next = buf_reg << 8;
            cnt_next = cnt_reg - 4'd1;
        end
        if (pop)
        begin
            if (head.is_flush)
            begin
                acc_next  = '0;
                fill_next = '0;
                bw_next   = bw_reg + CAP_W'(fl_cnt);
                buf_next  = {acc_reg, {WORD_BITS{1'b0}}};
                cnt_next  = {1'b0, fl_cnt};
            end
            else
            begin
                if (total[6])
                    acc_next = '0;
                else if (total[5])
                    acc_next = win[WORD_BITS-1:0];
                else
                    acc_next = win[2*WORD_BITS-1:WORD_BITS];
                fill_next = total[FILL_W-1:0];
                bw_next   = bw_reg + CAP_W'({ew, 2'b00});
                buf_next  = win;
                cnt_next  = {ew, 2'b00};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            fill_reg <= '0;
            bw_reg   <= '0;
            cap_reg  <= CAP_RESET;
            cnt_reg  <= '0;
        end
        else
        begin
            acc_reg  <= acc_next;
            fill_reg <= fill_next;
            bw_reg   <= bw_next;
            cnt_reg  <= cnt_next;
            if (cfg_write)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    `SEGE_ASSERT_NOW(a_no_overrun, clk, rst_n, cnt_reg > 4'd1, !pop, "overwrote pending bytes")
    `SEGE_ASSERT_NEXT(a_flush_clears, clk, rst_n, pop && head.is_flush, acc_reg == '0 && fill_reg == '0, "flush left bits")
    `SEGE_ASSERT_NEXT(a_idle_holds, clk, rst_n, !pop, $stable(acc_reg) && $stable(bw_reg) && $stable(fill_reg), "state moved without request")

endmodule

>>> rtl/core/signed_exp_golomb_bit_writer.sv
// Top level of the signed Exp-Golomb (order 0) bit writer.
// Depends on sege_pkg, sege_front, sege_queue, sege_back.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------
//  in      | in_valid / in_ready     | in_data  (req_type, coefficient)
//  out     | out_valid / out_ready   | out_data (out_byte, last_of_run)
//  cfg     | cfg_write               | cfg_data (byte_capacity)
//
// The packer handles one request per cycle; a request that produces bytes holds it
// until its last byte leaves.
// Bytes leave the drain register one per cycle while out_ready is high.
// The request queue (QUEUE_DEPTH entries) lets input and output stall independently.
// Reset sets the control registers at once, not the data storage; no clearing pass.
module signed_exp_golomb_bit_writer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  sege_pkg::in_item_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output sege_pkg::out_item_t        out_data,
    input  logic                       cfg_write,
    input  logic [sege_pkg::CAP_W-1:0] cfg_data
);
    import sege_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head;

    sege_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    sege_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    sege_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> tb/tb_signed_exp_golomb_bit_writer.sv
// Self-checking testbench for signed_exp_golomb_bit_writer: directed table, then random
// requests under several byte capacities, checked byte by byte against an internal packer model.
// Depends on sege_pkg and the RTL of the bit writer.
module tb_signed_exp_golomb_bit_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import sege_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int NUM_DIRECTED = 24;
    localparam int HOLD_CYCLES  = 80;

    typedef struct packed {
        in_item_t    req;
        int          n_bytes;   // -1: take the packer model's bytes
        logic [31:0] bytes;     // typed bytes, first byte most significant
    } dir_row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    in_item_t             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_write = 1'b0;
    logic [CAP_W-1:0]     cfg_data = '0;

    // packer model state
    logic [31:0]          acc_bits;
    int unsigned          acc_free;
    logic [CAP_W-1:0]     bytes_out;
    logic [CAP_W-1:0]     byte_cap;

    out_item_t            expected_bytes[$];
    int                   mismatches = 0;
    int                   bytes_seen = 0;
    int                   req_count = 0;
    int                   flush_count = 0;
    int                   cap_settings = 0;
    bit                   calm = 1'b0;

    dir_row_t dir_rows [0:NUM_DIRECTED-1] = '{
        '{'{REQ_ENCODE, 16'sh0000}, 0, 32'h0},
        '{'{REQ_FLUSH,  16'sh0000}, 1, 32'h80},
        '{'{REQ_FLUSH,  16'shFFFF}, 0, 32'h0},
        '{'{REQ_ENCODE, 16'sh8000}, 4, 32'h0000_8000},
        '{'{REQ_FLUSH,  16'sh1234}, 1, 32'h80},
        '{'{REQ_ENCODE, 16'sh7FFF}, 0, 32'h0},
        '{'{REQ_ENCODE, 16'sh0000}, 4, 32'h0001_FFFD},
        '{'{REQ_FLUSH,  16'sh0000}, 0, 32'h0},
        '{'{REQ_ENCODE, 16'sh7FFF}, -1, 32'h0},
        '{'{REQ_ENCODE, 16'sh8000}, -1, 32'h0},
        '{'{REQ_FLUSH,  16'sh0000}, -1, 32'h0},
        '{'{REQ_ENCODE, 16'sh0001}, -1, 32'h0},
        '{'{REQ_ENCODE, 16'shFFFF}, -1, 32'h0},
        '{'{REQ_ENCODE, 16'sh0002}, -1, 32'h0},
        '{'{REQ_ENCODE, 16'shFFFE}, -1, 32'h0},
        '{'{REQ_ENCODE, 16'sh00FF}, -1, 32'h0},
        '{'{REQ_ENCODE, 16'shFF00}, -1, 32'h0},
        '{'{REQ_ENCODE, 16'sh1000}, -1, 32'h0},
        '{'{REQ_ENCODE, 16'shCFC7}, -1, 32'h0},
        '{'{REQ_ENCODE, 16'sh5555}, -1, 32'h0},
        '{'{REQ_ENCODE, 16'shAAAA}, -1, 32'h0},
        '{'{REQ_FLUSH,  16'shAAAA}, -1, 32'h0},
        '{'{REQ_ENCODE, 16'sh0003}, -1, 32'h0},
        '{'{REQ_FLUSH,  16'sh5555}, -1, 32'h0}
    };

    signed_exp_golomb_bit_writer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void pack_bits(input logic [31:0] val, input int unsigned n,
                                      ref out_item_t res[$]);
        int unsigned rem;
        logic [31:0] word;
        if (n == 0)
            return;
        if (n < acc_free)
        begin
            acc_bits |= val << (acc_free - n);
            acc_free -= n;
            return;
        end
        rem = n - acc_free;
        word = acc_bits | (val >> rem);
        if ({8'd0, bytes_out} + 32'd4 <= {8'd0, byte_cap})
        begin
            for (int i = 3; i >= 0; i--)
                res.push_back('{word[8*i +: 8], 1'b0});
            bytes_out += 24'd4;
        end
        acc_bits = (rem == 0) ? 32'd0 : val << (32 - rem);
        acc_free = 32 - rem;
    endfunction

    function automatic void pack_request(input in_item_t r, ref out_item_t res[$]);
        int c;
        int code;
        int unsigned len;
        if (r.req_type == REQ_FLUSH)
        begin
            while (acc_free < 32)
            begin
                if (bytes_out < byte_cap)
                begin
                    res.push_back('{acc_bits[31:24], 1'b0});
                    bytes_out += 24'd1;
                end
                acc_bits <<= 8;
                acc_free += 8;
            end
            acc_bits = '0;
            acc_free = 32;
        end
        else
        begin
            c = $signed(r.coefficient);
            code = (c > 0) ? 2 * c - 1 : -2 * c;
            len = 0;
            for (int t = code + 1; t > 1; t >>= 1)
                len++;
            pack_bits(32'd0, len, res);
            pack_bits(32'(code + 1), len + 1, res);
        end
        if (res.size() > 0)
            res[res.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic in_item_t random_request();
        in_item_t r;
        int unsigned sel;
        int unsigned width;
        int unsigned mag;
        sel = $urandom_range(99);
        width = $urandom_range(16);
        mag = $urandom & ((32'd1 << width) - 1);
        r.req_type = (sel < 10) ? REQ_FLUSH : REQ_ENCODE;
        if (sel < 20)
            r.coefficient = 16'($urandom);
        else if (sel < 24)
            r.coefficient = sel[0] ? 16'sh8000 : 16'sh7FFF;
        else if ($urandom_range(1) == 1)
            r.coefficient = 16'(32'd0 - mag);
        else
            r.coefficient = 16'(mag);
        return r;
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    task automatic check_byte(input out_item_t got);
        out_item_t want;
        bytes_seen++;
        if (expected_bytes.size() == 0)
        begin
            note_mismatch($sformatf("unexpected byte %02h last=%0b",
                                    got.out_byte, got.last_of_run));
            return;
        end
        want = expected_bytes.pop_front();
        if (got.out_byte !== want.out_byte)
            note_mismatch($sformatf("byte %0d: out_byte expected %02h, got %02h",
                                    bytes_seen, want.out_byte, got.out_byte));
        if (got.last_of_run !== want.last_of_run)
            note_mismatch($sformatf("byte %0d: last_of_run expected %0b, got %0b",
                                    bytes_seen, want.last_of_run, got.last_of_run));
    endtask

    // n_typed < 0: expected bytes come from the packer model
    task automatic send_req(input in_item_t r, input int n_typed, input logic [31:0] typed);
        out_item_t res[$];
        if (!calm && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 30)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do
            @(posedge clk);
        while (!in_ready);
        req_count++;
        if (r.req_type == REQ_FLUSH)
            flush_count++;
        pack_request(r, res);
        if (n_typed < 0)
        begin
            foreach (res[i])
                expected_bytes.push_back(res[i]);
        end
        else
        begin
            for (int i = 0; i < n_typed; i++)
                expected_bytes.push_back('{typed[8*(n_typed-1-i) +: 8], i == n_typed - 1});
        end
    endtask

    task automatic drain_pending();
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        drain_pending();
        cfg_write <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        byte_cap = v;
        cap_settings++;
    endtask

    task automatic random_phase(input int count);
        for (int i = 0; i < count; i++)
            send_req(random_request(), -1, 32'h0);
    endtask

    initial
    begin : byte_sink
        int hold;
        bit held;
        hold = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                check_byte(out_data);
            // well into the first random phase, while requests keep coming
            if (!held && bytes_seen >= 100)
            begin
                held = 1'b1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= calm || ($urandom_range(99) >= 6);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timeout: no request or byte moved for %0d cycles", STALL_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        acc_bits = '0;
        acc_free = 32;
        bytes_out = '0;
        byte_cap = CAP_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_req(dir_rows[i].req, dir_rows[i].n_bytes, dir_rows[i].bytes);

        set_capacity(24'hFF_FFFF);
        for (int i = 0; i < 150; i++)
        begin
            calm = (i >= 40 && i < 100);
            send_req(random_request(), -1, 32'h0);
        end
        calm = 1'b0;

        // at most one word fits, then words and flush bytes get dropped
        set_capacity(bytes_out + 24'd6);
        random_phase(40);

        // below bytes already written: nothing may come out
        set_capacity(24'd0);
        random_phase(20);

        set_capacity(bytes_out + 24'($urandom_range(300)));
        random_phase(40);

        drain_pending();
        $display("Sent %0d requests (%0d flushes) over %0d capacity settings, %0d bytes checked,",
                 req_count, flush_count, cap_settings, bytes_seen);
        $display("with %0d mismatching fields.", mismatches);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
